// File: rtl/core/s2cd_pkg.sv
// Package for the seconds to calendar date converter.
// Holds the divider request type, divisor and reciprocal constants and calendar tables.
// No dependencies.
package s2cd_pkg;

  localparam int DIVW = 11;   // widest divisor is one four-year set of days

  typedef struct packed {
    logic [31:0]     dividend;
    logic [DIVW-1:0] divisor;
    logic [31:0]     recip;   // floor(2^32 / divisor)
  } div_req_t;

  localparam logic [DIVW-1:0] DIV_MS   = DIVW'(1000);
  localparam logic [DIVW-1:0] DIV_MIN  = DIVW'(60);
  localparam logic [DIVW-1:0] DIV_HOUR = DIVW'(24);
  localparam logic [DIVW-1:0] DIV_QUAD = DIVW'(366 + 3 * 365);
  localparam logic [DIVW-1:0] DIV_WEEK = DIVW'(7);

  // Reciprocals scaled by 2^32, rounded down. The estimate they give is at most
  // one below the true quotient for any 32-bit dividend.
  localparam logic [31:0] RCP_MS   = 32'(64'h1_0000_0000 / 64'(DIV_MS));
  localparam logic [31:0] RCP_MIN  = 32'(64'h1_0000_0000 / 64'(DIV_MIN));
  localparam logic [31:0] RCP_HOUR = 32'(64'h1_0000_0000 / 64'(DIV_HOUR));
  localparam logic [31:0] RCP_QUAD = 32'(64'h1_0000_0000 / 64'(DIV_QUAD));
  localparam logic [31:0] RCP_WEEK = 32'(64'h1_0000_0000 / 64'(DIV_WEEK));

  localparam logic [31:0] EPOCH_SHIFT = 32'd432000;
  localparam logic [11:0] BASE_YEAR   = 12'd1980;

  localparam logic [10:0] QUAD_START [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};
  localparam logic [2:0]  YEAR_WDAY  [4] = '{3'd1, 3'd3, 3'd4, 3'd5};

  localparam logic [8:0] LEAP_START [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};
  localparam logic [8:0] COMMON_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

endpackage

// File: rtl/core/seconds_to_calendar_date.sv
// Top level of the GPS seconds to calendar date converter.
// Depends on s2cd_pkg and on the shared divider s2cd_div.
//
//  channel   signals                              handshake
//  --------  -----------------------------------  ------------------------------
//  command   start, opcode, elapsed               beat taken when start && !busy
//  result    valid, year, month, day, hour,       one-cycle strobe on valid
//            minute, second, weekday
//
// Every division runs through one reciprocal-multiply unit. A request is handed
// over on a registered go, runs three steps inside the unit (multiply by the
// reciprocal, multiply back and subtract, one correction step) and is picked up
// on done. A seconds beat makes five requests (/60, /60, /24, /1461, /7); a
// millisecond beat first divides by 1000 as four 16-bit digits of long division.
// Reset is synchronous and clears only the sequencer and the div_go and valid
// strobes. The receiver cannot stall: the result stays on the ports until the
// next beat writes it; valid is high for one cycle; busy drops in the cycle valid rises.
module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] elapsed,
  output logic        valid,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday
);

  typedef enum logic [3:0] {
    S_IDLE, S_DMS, S_ADD, S_DSEC, S_DMIN, S_DHOUR, S_DQUAD, S_YEAR, S_DWEEK
  } state_t;

  state_t   state;
  logic     div_go;
  div_req_t div_req;
  logic     div_done;
  logic [31:0]     div_quot;
  logic [DIVW-1:0] div_rem;

  logic [31:0] secs;
  logic [47:0] ms_rest;   // millisecond digits still to divide, top digit first
  logic [1:0]  digit;
  logic [5:0]  quads;
  logic [10:0] days4;     // day within the four-year set
  logic [1:0]  yidx;
  logic [8:0]  dayyr;     // day within the year

  s2cd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Year within the set: count how many later year starts the day has passed.
  logic [1:0]  yidx_c;
  logic [10:0] dayyr_c;
  logic [9:0]  week_sum;

  always_comb begin
    yidx_c = '0;
    for (int i = 1; i < 4; i++) begin
      if (days4 >= QUAD_START[i]) yidx_c = 2'(i);
    end
    dayyr_c  = days4 - QUAD_START[yidx_c];
    week_sum = 10'(({4'b0, quads} << 2) + {4'b0, quads}) + 10'(YEAR_WDAY[yidx_c])
             + 10'(dayyr_c);
  end

  // Month search over the table of the year type; the first year of a set is leap.
  logic [3:0] midx_c;
  logic [8:0] mstart_c;

  always_comb begin
    midx_c = '0;
    for (int i = 1; i < 12; i++) begin
      if (yidx == 2'd0) begin
        if (dayyr >= LEAP_START[i]) midx_c = 4'(i);
      end else begin
        if (dayyr >= COMMON_START[i]) midx_c = 4'(i);
      end
    end
    mstart_c = (yidx == 2'd0) ? LEAP_START[midx_c] : COMMON_START[midx_c];
  end

  logic [31:0] secs_shift;
  assign secs_shift = secs + EPOCH_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      valid  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      valid  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (opcode) begin
              // Long division by 1000 starts on the top 16-bit digit with no remainder.
              div_req <= '{dividend: {16'b0, elapsed[63:48]}, divisor: DIV_MS,
                           recip: RCP_MS};
              div_go  <= 1'b1;
              ms_rest <= elapsed[47:0];
              digit   <= 2'd0;
              state   <= S_DMS;
            end else begin
              secs  <= elapsed[31:0];
              state <= S_ADD;
            end
          end
        end
        S_DMS: begin
          // Each digit of the quotient is below 2^16, so after the last digit the
          // low 32 bits of the quotient are the last two digits.
          if (div_done) begin
            secs <= {secs[15:0], div_quot[15:0]};
            if (digit == 2'd3) begin
              state <= S_ADD;
            end else begin
              div_req <= '{dividend: {6'b0, div_rem[9:0], ms_rest[47:32]},
                           divisor: DIV_MS, recip: RCP_MS};
              div_go  <= 1'b1;
              ms_rest <= {ms_rest[31:0], 16'b0};
              digit   <= digit + 2'd1;
            end
          end
        end
        S_ADD: begin
          div_req <= '{dividend: secs_shift, divisor: DIV_MIN, recip: RCP_MIN};
          div_go  <= 1'b1;
          state   <= S_DSEC;
        end
        S_DSEC: begin
          if (div_done) begin
            second  <= 6'(div_rem);
            div_req <= '{dividend: div_quot, divisor: DIV_MIN, recip: RCP_MIN};
            div_go  <= 1'b1;
            state   <= S_DMIN;
          end
        end
        S_DMIN: begin
          if (div_done) begin
            minute  <= 6'(div_rem);
            div_req <= '{dividend: div_quot, divisor: DIV_HOUR, recip: RCP_HOUR};
            div_go  <= 1'b1;
            state   <= S_DHOUR;
          end
        end
        S_DHOUR: begin
          if (div_done) begin
            hour    <= 5'(div_rem);
            div_req <= '{dividend: div_quot, divisor: DIV_QUAD, recip: RCP_QUAD};
            div_go  <= 1'b1;
            state   <= S_DQUAD;
          end
        end
        S_DQUAD: begin
          if (div_done) begin
            quads <= div_quot[5:0];
            days4 <= div_rem;
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          yidx    <= yidx_c;
          dayyr   <= dayyr_c[8:0];
          year    <= BASE_YEAR + {4'b0, quads, 2'b00} + {10'b0, yidx_c};
          div_req <= '{dividend: {22'b0, week_sum}, divisor: DIV_WEEK, recip: RCP_WEEK};
          div_go  <= 1'b1;
          state   <= S_DWEEK;
        end
        S_DWEEK: begin
          if (div_done) begin
            weekday <= 3'(div_rem);
            month   <= midx_c + 4'd1;
            day     <= 5'(dayyr - mstart_c + 9'd1);
            valid   <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/core/s2cd_div.sv
// Shared divider by a constant, using multiplication by a scaled reciprocal.
// Depends on s2cd_pkg for the request type and widths.
module s2cd_div
  import s2cd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  div_req_t        req,
  output logic            done,
  output logic [31:0]     quot,
  output logic [DIVW-1:0] rem
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_BACK, D_FIX} dstate_t;

  dstate_t         state;
  logic [31:0]     num;
  logic [DIVW-1:0] divs;
  logic [31:0]     recip;
  logic [31:0]     q_est;
  logic [DIVW:0]   r_est;     // below twice the divisor

  logic [63:0]     prod;
  logic [31:0]     back;
  logic [31:0]     diff;
  logic [DIVW:0]   r_fix;
  logic            over;

  assign prod  = 64'(num) * 64'(recip);
  assign back  = q_est * 32'(divs);
  assign diff  = num - back;
  assign r_fix = r_est - {1'b0, divs};
  assign over  = (r_est >= {1'b0, divs});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (go) begin
            num   <= req.dividend;
            divs  <= req.divisor;
            recip <= req.recip;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          q_est <= prod[63:32];
          state <= D_BACK;
        end
        D_BACK: begin
          // The estimate is exact or one low, so the remainder fits in DIVW+1 bits.
          r_est <= diff[DIVW:0];
          state <= D_FIX;
        end
        D_FIX: begin
          if (over) begin
            quot <= q_est + 32'd1;
            rem  <= r_fix[DIVW-1:0];
          end else begin
            quot <= q_est;
            rem  <= r_est[DIVW-1:0];
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule
